/* hdl/irqslm_pkg.sv */
package irqslm_pkg;

    // command codes
    localparam logic [1:0] CMD_SET_LEVEL = 2'd0;
    localparam logic [1:0] CMD_REQUEST   = 2'd1;
    localparam logic [1:0] CMD_FREE      = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // chip select codes
    localparam logic CHIP_PIC    = 1'b0;
    localparam logic CHIP_IOAPIC = 1'b1;

    // pin store control for one item
    typedef struct packed {
        logic       set_en;   // update the addressed pin word
        logic       clr_en;   // clear the source bit on every pin
        logic       chip;
        logic [4:0] pin;
        logic       level;
    } t_pin_req;

    // allocator control for one item
    typedef struct packed {
        logic grant_en;
        logic free_en;
    } t_alloc_req;

endpackage

/* hdl/irqslm_pin_store.sv */
module irqslm_pin_store #(
    parameter int NUM_SOURCES = 64,
    parameter int IOAPIC_PINS = 24,
    parameter int PIC_PINS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  irqslm_pkg::t_pin_req      i_req,
    input  logic [NUM_SOURCES-1:0]    i_src_mask,
    output logic                      o_merged_level
);

    localparam int PIC_IDX_W = $clog2(PIC_PINS);
    localparam int IO_IDX_W  = (IOAPIC_PINS > 1) ? $clog2(IOAPIC_PINS) : 1;

    logic [NUM_SOURCES-1:0] r_pic [PIC_PINS];
    logic [NUM_SOURCES-1:0] r_io  [IOAPIC_PINS];

    logic [5:0]             pin_ext;
    logic [PIC_IDX_W-1:0]   pic_idx;
    logic [IO_IDX_W-1:0]    io_idx;
    logic [NUM_SOURCES-1:0] cur_word;
    logic [NUM_SOURCES-1:0] n_word;

    assign pin_ext = {1'b0, i_req.pin};
    assign pic_idx = pin_ext[PIC_IDX_W-1:0];
    assign io_idx  = pin_ext[IO_IDX_W-1:0];

    always_comb begin
        if (i_req.chip == irqslm_pkg::CHIP_IOAPIC) begin
            cur_word = r_io[io_idx];
        end else begin
            cur_word = r_pic[pic_idx];
        end
        n_word = i_req.level ? (cur_word | i_src_mask) : (cur_word & ~i_src_mask);
    end

    assign o_merged_level = |n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIC_PINS; i++) begin
                r_pic[i] <= '0;
            end
            for (int i = 0; i < IOAPIC_PINS; i++) begin
                r_io[i] <= '0;
            end
        end else begin
            for (int i = 0; i < PIC_PINS; i++) begin
                if (i_req.clr_en) begin
                    r_pic[i] <= r_pic[i] & ~i_src_mask;
                end else if (i_req.set_en && i_req.chip == irqslm_pkg::CHIP_PIC
                             && pic_idx == PIC_IDX_W'(i)) begin
                    r_pic[i] <= n_word;
                end
            end
            for (int i = 0; i < IOAPIC_PINS; i++) begin
                if (i_req.clr_en) begin
                    r_io[i] <= r_io[i] & ~i_src_mask;
                end else if (i_req.set_en && i_req.chip == irqslm_pkg::CHIP_IOAPIC
                             && io_idx == IO_IDX_W'(i)) begin
                    r_io[i] <= n_word;
                end
            end
        end
    end

    // a set with level high always leaves the pin asserted
    a_set_high_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.set_en && i_req.level) |-> o_merged_level)
        else $error("asserting set did not raise merged level");

endmodule

/* hdl/irqslm_alloc.sv */
module irqslm_alloc #(
    parameter int NUM_SOURCES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  irqslm_pkg::t_alloc_req    i_req,
    input  logic [NUM_SOURCES-1:0]    i_src_mask,
    output logic                      o_found,
    output logic [5:0]                o_free_id
);

    logic [NUM_SOURCES-1:0] r_map;
    logic [NUM_SOURCES-1:0] n_map;
    logic [NUM_SOURCES-1:0] grant_mask;

    // lowest clear bit: scan downward so the lowest hit wins
    always_comb begin
        o_found   = 1'b0;
        o_free_id = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (!r_map[i]) begin
                o_found   = 1'b1;
                o_free_id = 6'(i);
            end
        end
    end

    assign grant_mask = NUM_SOURCES'(1) << o_free_id;

    always_comb begin
        n_map = r_map;
        if (i_req.grant_en) begin
            n_map = r_map | grant_mask;
        end else if (i_req.free_en) begin
            n_map = r_map & ~i_src_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= NUM_SOURCES'(1);
        end else begin
            r_map <= n_map;
        end
    end

    a_reserved_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map[0])
        else $error("reserved source id lost its allocation");

    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.grant_en |=> (r_map & $past(grant_mask)) != '0)
        else $error("granted id not marked allocated");

endmodule

/* hdl/irq_source_line_merger_top.sv */
// Pipeline: two register stages, input and result; the result register drives the outputs.
// Throughput: one item per cycle; the input stage advances whenever the
//   result register is empty or being taken.
// Reset (i_rst_n, synchronous, active low): all pin words cleared, only source
//   id 0 allocated, irqchip_enabled set to 1, both stages empty.
module irq_source_line_merger_top #(
    parameter int NUM_SOURCES = 64,
    parameter int IOAPIC_PINS = 24,
    parameter int PIC_PINS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // configuration: irqchip_enabled
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,

    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic       i_chip_select,
    input  logic [4:0] i_pin,
    input  logic [5:0] i_source_id,
    input  logic       i_level,

    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_merged_level,
    output logic [5:0] o_granted_source
);

    localparam int SRC_IDX_W = $clog2(NUM_SOURCES);

    // config register
    logic r_irqchip_en;

    // input stage
    logic       r_in_valid;
    logic [1:0] r_command;
    logic       r_chip;
    logic [4:0] r_pin;
    logic [5:0] r_src;
    logic       r_level;

    // result stage
    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_merged;
    logic [5:0] r_granted;

    logic       in_accept;
    logic       adv;        // input stage item moves into the result register
    logic       fire;       // an item is processed this cycle
    logic       src_ok;
    logic       pin_ok;
    logic       set_do;
    logic       free_do;
    logic       req_do;
    logic       store_merged;
    logic       alloc_found;
    logic [5:0] alloc_id;
    logic [1:0] n_status;
    logic       n_merged;
    logic [5:0] n_granted;
    logic [NUM_SOURCES-1:0] src_mask;

    irqslm_pkg::t_pin_req   pin_req;
    irqslm_pkg::t_alloc_req alloc_req;

    // Handshake: the result register parts the two channels, so a new item
    // is taken while the previous result waits only if the input stage is
    // empty, else only as it hands over its own item in the same edge.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irqchip_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_irqchip_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= i_command;
            r_chip    <= i_chip_select;
            r_pin     <= i_pin;
            r_src     <= i_source_id;
            r_level   <= i_level;
        end
    end

    // Range checks. Widening to int keeps them right for any parameter value.
    assign src_ok = 32'(r_src) < NUM_SOURCES;
    assign pin_ok = (r_chip == irqslm_pkg::CHIP_IOAPIC) ? (32'(r_pin) < IOAPIC_PINS)
                                                        : (32'(r_pin) < PIC_PINS);

    // One-hot source bit; only used when src_ok holds.
    assign src_mask = NUM_SOURCES'(1) << r_src[SRC_IDX_W-1:0];

    // State updates happen only on the edge the item leaves the input stage.
    assign set_do  = fire && r_command == irqslm_pkg::CMD_SET_LEVEL && src_ok && pin_ok;
    assign free_do = fire && r_command == irqslm_pkg::CMD_FREE && src_ok && r_src != '0;
    assign req_do  = fire && r_command == irqslm_pkg::CMD_REQUEST && alloc_found;

    always_comb begin
        pin_req.set_en     = set_do;
        pin_req.clr_en     = free_do && r_irqchip_en;
        pin_req.chip       = r_chip;
        pin_req.pin        = r_pin;
        pin_req.level      = r_level;
        alloc_req.grant_en = req_do;
        alloc_req.free_en  = free_do;
    end

    irqslm_pin_store #(
        .NUM_SOURCES (NUM_SOURCES),
        .IOAPIC_PINS (IOAPIC_PINS),
        .PIC_PINS    (PIC_PINS)
    ) u_pin_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (pin_req),
        .i_src_mask     (src_mask),
        .o_merged_level (store_merged)
    );

    irqslm_alloc #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_alloc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (alloc_req),
        .i_src_mask (src_mask),
        .o_found    (alloc_found),
        .o_free_id  (alloc_id)
    );

    // Result fields. Anything not done reports zero level and zero id.
    always_comb begin
        n_status  = irqslm_pkg::ST_IGNORED;
        n_merged  = 1'b0;
        n_granted = '0;
        unique case (r_command)
            irqslm_pkg::CMD_SET_LEVEL: begin
                if (src_ok && pin_ok) begin
                    n_status = irqslm_pkg::ST_DONE;
                    n_merged = store_merged;
                end
            end
            irqslm_pkg::CMD_REQUEST: begin
                if (alloc_found) begin
                    n_status  = irqslm_pkg::ST_DONE;
                    n_granted = alloc_id;
                end else begin
                    n_status  = irqslm_pkg::ST_NO_FREE;
                end
            end
            irqslm_pkg::CMD_FREE: begin
                // reserved id 0 and ids beyond the source count are ignored
                if (src_ok && r_src != '0) begin
                    n_status = irqslm_pkg::ST_DONE;
                end
            end
            default: begin
                n_status = irqslm_pkg::ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= n_status;
            r_merged  <= n_merged;
            r_granted <= n_granted;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_merged_level   = r_merged;
    assign o_granted_source = r_granted;

    // an item held in the input stage is not dropped
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input stage item lost while blocked");

    // only a completed set reports an asserted line
    a_merged_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_merged_level) |-> (o_status == irqslm_pkg::ST_DONE))
        else $error("merged level on a result that was not done");

    // failed or ignored items carry no grant
    a_no_grant_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != irqslm_pkg::ST_DONE) |-> (o_granted_source == '0))
        else $error("grant reported on a failed item");

endmodule
